// File: rtl/core/vsc_pkg.sv
// Shared types, codes and constants of the viewport scroll controller.
`timescale 1ns / 1ps

package vsc_pkg;

   // Port widths.
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int OUT_TILE_W = 12;

   // Request kinds carried in req_tuser; the fourth code changes no view state but still returns a result.
   localparam logic [1:0] REQ_ACCEL = 2'd0;
   localparam logic [1:0] REQ_ABS   = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   // Control register indexes.
   localparam logic [2:0] CSR_SCROLL_STEP = 3'd0;
   localparam logic [2:0] CSR_MAX_SCROLL  = 3'd1;
   localparam logic [2:0] CSR_SCROLL_TIME = 3'd2;
   localparam logic [2:0] CSR_TILE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_MAX_TILE_X  = 3'd4;
   localparam logic [2:0] CSR_MAX_TILE_Y  = 3'd5;
   localparam logic [2:0] CSR_MAX_OFF_X   = 3'd6;
   localparam logic [2:0] CSR_MAX_OFF_Y   = 3'd7;

   // Control register reset values.
   localparam logic [6:0]  RST_SCROLL_STEP = 7'd1;
   localparam logic [6:0]  RST_MAX_SCROLL  = 7'd16;
   localparam logic [7:0]  RST_SCROLL_TIME = 8'd4;
   localparam logic [7:0]  RST_TILE_WIDTH  = 8'd24;

   // Direction bit positions.
   localparam int DIR_UP    = 0;
   localparam int DIR_DOWN  = 1;
   localparam int DIR_LEFT  = 2;
   localparam int DIR_RIGHT = 3;
   localparam logic [3:0] DIRS_RESET = 4'b1010;

   // Velocity magnitude limit and pointer offset clamp.
   localparam logic [7:0]  VEL_LIMIT = 8'd127;
   localparam logic [11:0] ABS_LIM   = 12'd100;

   // x / 100 as (x * 5243) >> 19, exact for x up to 12700.
   localparam logic [12:0] RCP_MUL   = 13'd5243;
   localparam int          RCP_SHIFT = 19;

   // Tile carry divider.
   localparam int DIV_N_W   = 9;
   localparam int DIV_D_W   = 8;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACC,
      S_ACC_END,
      S_ABS_MUL,
      S_ABS_RCP,
      S_ABS_END,
      S_T_MUL,
      S_T_CLAMP,
      S_T_CHECK,
      S_T_DIV,
      S_T_WAIT,
      S_T_CARRY,
      S_T_END,
      S_DONE
   } vsc_state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LATCH,
      OP_ACC_STEP,
      OP_ACC_END,
      OP_ABS_MUL,
      OP_ABS_RCP,
      OP_ABS_END,
      OP_T_MUL,
      OP_T_CLAMP,
      OP_T_STOP,
      OP_T_DIV,
      OP_T_CARRY,
      OP_T_END,
      OP_LOAD_OUT
   } vsc_op_type;

   // sel is the direction index during acceleration and the axis (bit 0) during a tick.
   typedef struct packed {
      vsc_op_type op;
      logic [1:0] sel;
   } vsc_cmd_type;

   typedef struct packed {
      logic vel_zero;
      logic div_done;
   } vsc_stat_type;

endpackage

// File: rtl/core/vsc_div.sv
// Restoring divider, one quotient bit per cycle, for the tile carry.
`timescale 1ns / 1ps

module vsc_div
   import vsc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient,
   output logic [DIV_D_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_D_W:0]     trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = DIV_CNT_W'(DIV_N_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits in DIV_D_W bits.
         rem_in = fits ? DIV_D_W'(trial - {1'b0, dvs_ff}) : trial[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/core/vsc_dp.sv
// Datapath: control registers, view state, velocity and position arithmetic, result register.
`timescale 1ns / 1ps

module vsc_dp
   import vsc_pkg::*;
#(
   parameter int TILE_POS_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  vsc_cmd_type           cmd,
   output vsc_stat_type          stat,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int TPB = TILE_POS_BITS;
   localparam int PW  = TPB + 8;
   localparam int PW1 = PW + 1;
   localparam int SW  = TPB + 11;

   // Control registers.
   logic [6:0]  step_ff, step_in;
   logic [6:0]  maxs_ff, maxs_in;
   logic [7:0]  stime_ff, stime_in;
   logic [7:0]  tw_ff, tw_in;
   logic [11:0] mtx_ff, mtx_in;
   logic [11:0] mty_ff, mty_in;
   logic [7:0]  mox_ff, mox_in;
   logic [7:0]  moy_ff, moy_in;

   // Latched request.
   logic [3:0]  dir_ff, dir_in;
   logic [11:0] dx_ff, dx_in;
   logic [11:0] dy_ff, dy_in;
   logic [7:0]  border_ff, border_in;
   logic [3:0]  dout_ff, dout_in;
   logic        vx_ff, vx_in;
   logic        vy_ff, vy_in;

   // View state.
   logic [TPB-1:0] tile_x_ff, tile_x_in;
   logic [TPB-1:0] tile_y_ff, tile_y_in;
   logic [7:0]     off_x_ff, off_x_in;
   logic [7:0]     off_y_ff, off_y_in;
   logic [7:0]     vel_x_ff, vel_x_in;
   logic [7:0]     vel_y_ff, vel_y_in;
   logic [7:0]     hold_ff, hold_in;
   logic           active_ff, active_in;
   logic [3:0]     allowed_ff, allowed_in;

   // Intermediate results.
   logic [13:0]  pmag_x_ff, pmag_x_in;
   logic [13:0]  pmag_y_ff, pmag_y_in;
   logic         pneg_x_ff, pneg_x_in;
   logic         pneg_y_ff, pneg_y_in;
   logic [6:0]   q_x_ff, q_x_in;
   logic [6:0]   q_y_ff, q_y_in;
   logic [PW-1:0] p_ff, p_in;
   logic [PW-1:0] mp_ff, mp_in;
   logic          nneg_ff, nneg_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [7:0]     eff_tw;
   logic           ax;
   logic [TPB-1:0] mtx_ext, mty_ext;
   logic [TPB-1:0] cur_tile, cur_mt;
   logic [7:0]     cur_off, cur_mo, cur_vel, vmag;
   logic [3:0]     mask_now;
   logic           on_y, pos_dir, acc_ok;
   logic [7:0]     acc_v;
   logic [8:0]     acc_vs, acc_step, acc_sum, acc_rs;
   logic [7:0]     acc_new;
   logic [6:0]     cm_x, cm_y;
   logic [26:0]    rcp_x, rcp_y;
   logic [12:0]    sdx, sdy, sbrd, nbrd;
   logic           le_x, ge_x, le_y, ge_y;
   logic [7:0]     absv_x, absv_y;
   logic [PW-1:0]  tile_wide, mt_wide, tw_wide, p_calc, mp_calc;
   logic           low_hit, high_hit;
   logic [9:0]     n10;
   logic [DIV_N_W-1:0] nmag, div_q;
   logic [DIV_D_W-1:0] div_r, r_new;
   logic [10:0]    qs;
   logic [SW-1:0]  tile_sum;
   logic [TPB-1:0] tile_new;
   logic [7:0]     hold_next;
   logic           div_start, div_done;

   function automatic logic [6:0] clamp_mag(input logic [11:0] d);
      logic [11:0] m;
      if ($signed(d) > $signed(ABS_LIM) || $signed(d) < -$signed(ABS_LIM)) begin
         m = ABS_LIM;
      end else if (d[11]) begin
         m = 12'd0 - d;
      end else begin
         m = d;
      end
      return m[6:0];
   endfunction

   // Halve, rounding toward zero.
   function automatic logic [7:0] halve(input logic [7:0] v);
      logic [8:0] t;
      t = {v[7], v} + {8'd0, v[7]};
      return t[8:1];
   endfunction

   assign eff_tw  = (tw_ff == 8'd0) ? 8'd1 : tw_ff;
   assign mtx_ext = TPB'(mtx_ff);
   assign mty_ext = TPB'(mty_ff);

   // Per-axis selection for the tick steps.
   assign ax       = cmd.sel[0];
   assign cur_tile = ax ? tile_y_ff : tile_x_ff;
   assign cur_off  = ax ? off_y_ff : off_x_ff;
   assign cur_vel  = ax ? vel_y_ff : vel_x_ff;
   assign cur_mt   = ax ? mty_ext : mtx_ext;
   assign cur_mo   = ax ? moy_ff : mox_ff;
   assign vmag     = cur_vel[7] ? 8'd0 - cur_vel : cur_vel;

   always_comb begin
      mask_now = 4'hF;
      if (tile_x_ff == '0 && off_x_ff == 8'd0) mask_now[DIR_LEFT] = 1'b0;
      if (tile_y_ff == '0 && off_y_ff == 8'd0) mask_now[DIR_UP] = 1'b0;
      if (tile_x_ff == mtx_ext && off_x_ff == mox_ff) mask_now[DIR_RIGHT] = 1'b0;
      if (tile_y_ff == mty_ext && off_y_ff == moy_ff) mask_now[DIR_DOWN] = 1'b0;
   end

   // One accelerate step for the direction in cmd.sel, worked along that direction's sign.
   assign on_y     = !cmd.sel[1];
   assign pos_dir  = cmd.sel[0];
   assign acc_ok   = allowed_ff[cmd.sel];
   assign acc_v    = on_y ? vel_y_ff : vel_x_ff;
   assign acc_vs   = pos_dir ? {acc_v[7], acc_v} : 9'd0 - {acc_v[7], acc_v};
   assign acc_step = {2'b00, step_ff};
   assign acc_sum  = acc_vs + acc_step;

   always_comb begin
      if (acc_vs[8] || acc_vs == 9'd0) begin
         acc_rs = acc_step;
      end else if ($signed(acc_vs) < $signed({2'b00, maxs_ff})) begin
         acc_rs = (acc_sum > {1'b0, VEL_LIMIT}) ? {1'b0, VEL_LIMIT} : acc_sum;
      end else begin
         acc_rs = acc_vs;
      end
   end

   assign acc_new = pos_dir ? acc_rs[7:0] : 8'd0 - acc_rs[7:0];

   // Pointer mode.
   assign cm_x  = clamp_mag(dx_ff);
   assign cm_y  = clamp_mag(dy_ff);
   assign rcp_x = 27'(pmag_x_ff) * 27'(RCP_MUL);
   assign rcp_y = 27'(pmag_y_ff) * 27'(RCP_MUL);
   assign sdx   = {dx_ff[11], dx_ff};
   assign sdy   = {dy_ff[11], dy_ff};
   assign sbrd  = {5'd0, border_ff};
   assign nbrd  = 13'd0 - sbrd;
   assign le_x  = $signed(sdx) <= $signed(nbrd);
   assign ge_x  = $signed(sdx) >= $signed(sbrd);
   assign le_y  = $signed(sdy) <= $signed(nbrd);
   assign ge_y  = $signed(sdy) >= $signed(sbrd);
   assign absv_x = pneg_x_ff ? 8'd0 - {1'b0, q_x_ff} : {1'b0, q_x_ff};
   assign absv_y = pneg_y_ff ? 8'd0 - {1'b0, q_y_ff} : {1'b0, q_y_ff};

   // Linear pixel positions for the bound checks.
   assign tile_wide = PW'(cur_tile);
   assign mt_wide   = PW'(cur_mt);
   assign tw_wide   = PW'(eff_tw);
   assign p_calc    = tile_wide * tw_wide + PW'(cur_off);
   assign mp_calc   = mt_wide * tw_wide + PW'(cur_mo);
   assign low_hit   = cur_vel[7] && (p_ff <= PW'(vmag));
   assign high_hit  = !cur_vel[7] && (cur_vel != 8'd0) &&
                      ({1'b0, p_ff} + PW1'(vmag) >= {1'b0, mp_ff});

   // Offset plus velocity is split into whole tiles and a remainder by floor division.
   assign n10       = {2'b00, cur_off} + {{2{cur_vel[7]}}, cur_vel};
   assign nmag      = n10[9] ? DIV_N_W'(10'd0 - n10) : n10[DIV_N_W-1:0];
   assign div_start = (cmd.op == OP_T_DIV);

   always_comb begin
      if (!nneg_ff) begin
         qs = {2'b00, div_q};
      end else if (div_r == '0) begin
         qs = 11'd0 - {2'b00, div_q};
      end else begin
         qs = 11'd0 - {2'b00, div_q} - 11'd1;
      end
   end

   assign r_new    = (nneg_ff && div_r != '0) ? eff_tw - div_r : div_r;
   assign tile_sum = SW'(cur_tile) + {{(SW - 11){qs[10]}}, qs};
   assign tile_new = tile_sum[TPB-1:0];
   assign hold_next = (hold_ff == 8'hFF) ? hold_ff : hold_ff + 8'd1;

   vsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (nmag),
      .divisor   (eff_tw),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Control register writes.
   always_comb begin
      step_in  = step_ff;
      maxs_in  = maxs_ff;
      stime_in = stime_ff;
      tw_in    = tw_ff;
      mtx_in   = mtx_ff;
      mty_in   = mty_ff;
      mox_in   = mox_ff;
      moy_in   = moy_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SCROLL_STEP: step_in  = csr_wdata[6:0];
            CSR_MAX_SCROLL:  maxs_in  = csr_wdata[6:0];
            CSR_SCROLL_TIME: stime_in = csr_wdata[7:0];
            CSR_TILE_WIDTH:  tw_in    = csr_wdata[7:0];
            CSR_MAX_TILE_X:  mtx_in   = csr_wdata;
            CSR_MAX_TILE_Y:  mty_in   = csr_wdata;
            CSR_MAX_OFF_X:   mox_in   = csr_wdata[7:0];
            CSR_MAX_OFF_Y:   moy_in   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Operation decoder.
   always_comb begin
      dir_in      = dir_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      border_in   = border_ff;
      dout_in     = dout_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      tile_x_in   = tile_x_ff;
      tile_y_in   = tile_y_ff;
      off_x_in    = off_x_ff;
      off_y_in    = off_y_ff;
      vel_x_in    = vel_x_ff;
      vel_y_in    = vel_y_ff;
      hold_in     = hold_ff;
      active_in   = active_ff;
      allowed_in  = allowed_ff;
      pmag_x_in   = pmag_x_ff;
      pmag_y_in   = pmag_y_ff;
      pneg_x_in   = pneg_x_ff;
      pneg_y_in   = pneg_y_ff;
      q_x_in      = q_x_ff;
      q_y_in      = q_y_ff;
      p_in        = p_ff;
      mp_in       = mp_ff;
      nneg_in     = nneg_ff;
      rsp_data_in = rsp_data_ff;

      unique case (cmd.op)
         OP_IDLE: ;
         OP_LATCH: begin
            dir_in    = req_tdata[3:0];
            dx_in     = req_tdata[15:4];
            dy_in     = req_tdata[27:16];
            border_in = req_tdata[35:28];
            dout_in   = 4'd0;
            vx_in     = 1'b0;
            vy_in     = 1'b0;
         end
         OP_ACC_STEP: begin
            if (dir_ff[cmd.sel]) begin
               if (!acc_ok) begin
                  dir_in[cmd.sel] = 1'b0;
               end
               if (on_y) begin
                  vel_y_in = acc_ok ? acc_new : 8'd0;
                  vy_in    = acc_ok;
               end else begin
                  vel_x_in = acc_ok ? acc_new : 8'd0;
                  vx_in    = acc_ok;
               end
            end
         end
         OP_ACC_END: begin
            if (vx_ff || vy_ff) begin
               hold_in   = 8'd0;
               active_in = 1'b1;
            end
            dout_in = dir_ff;
         end
         OP_ABS_MUL: begin
            pmag_x_in = 14'(cm_x) * 14'(maxs_ff);
            pmag_y_in = 14'(cm_y) * 14'(maxs_ff);
            pneg_x_in = dx_ff[11];
            pneg_y_in = dy_ff[11];
         end
         OP_ABS_RCP: begin
            q_x_in = rcp_x[RCP_SHIFT+6:RCP_SHIFT];
            q_y_in = rcp_y[RCP_SHIFT+6:RCP_SHIFT];
         end
         OP_ABS_END: begin
            // A pointer at or past the negative border wins over the positive one.
            if (le_x) begin
               vel_x_in = allowed_ff[DIR_LEFT] ? absv_x : 8'd0;
               dout_in[DIR_LEFT] = allowed_ff[DIR_LEFT];
            end else if (ge_x) begin
               vel_x_in = allowed_ff[DIR_RIGHT] ? absv_x : 8'd0;
               dout_in[DIR_RIGHT] = allowed_ff[DIR_RIGHT];
            end
            if (le_y) begin
               vel_y_in = allowed_ff[DIR_UP] ? absv_y : 8'd0;
               dout_in[DIR_UP] = allowed_ff[DIR_UP];
            end else if (ge_y) begin
               vel_y_in = allowed_ff[DIR_DOWN] ? absv_y : 8'd0;
               dout_in[DIR_DOWN] = allowed_ff[DIR_DOWN];
            end
            active_in = (le_x && allowed_ff[DIR_LEFT]) ||
                        (!le_x && ge_x && allowed_ff[DIR_RIGHT]) ||
                        (le_y && allowed_ff[DIR_UP]) ||
                        (!le_y && ge_y && allowed_ff[DIR_DOWN]);
         end
         OP_T_MUL: begin
            p_in  = p_calc;
            mp_in = mp_calc;
         end
         OP_T_CLAMP: begin
            if (low_hit || high_hit) begin
               hold_in = 8'd0;
               if (ax) begin
                  vel_y_in  = 8'd0;
                  tile_y_in = low_hit ? '0 : cur_mt;
                  off_y_in  = low_hit ? 8'd0 : cur_mo;
               end else begin
                  vel_x_in  = 8'd0;
                  tile_x_in = low_hit ? '0 : cur_mt;
                  off_x_in  = low_hit ? 8'd0 : cur_mo;
               end
            end
         end
         OP_T_STOP: begin
            active_in  = 1'b0;
            allowed_in = mask_now;
         end
         OP_T_DIV: begin
            nneg_in = n10[9];
         end
         OP_T_CARRY: begin
            if (ax) begin
               tile_y_in = tile_new;
               off_y_in  = r_new;
            end else begin
               tile_x_in = tile_new;
               off_x_in  = r_new;
            end
         end
         OP_T_END: begin
            hold_in = hold_next;
            if (hold_next >= stime_ff) begin
               vel_x_in = halve(vel_x_ff);
               vel_y_in = halve(vel_y_ff);
            end
            allowed_in = mask_now;
         end
         OP_LOAD_OUT: begin
            rsp_data_in = {7'd0, active_ff, vel_y_ff, vel_x_ff, off_y_ff, off_x_ff,
                           OUT_TILE_W'(tile_y_ff), OUT_TILE_W'(tile_x_ff),
                           allowed_ff, dout_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= RST_SCROLL_STEP;
         maxs_ff    <= RST_MAX_SCROLL;
         stime_ff   <= RST_SCROLL_TIME;
         tw_ff      <= RST_TILE_WIDTH;
         mtx_ff     <= '0;
         mty_ff     <= '0;
         mox_ff     <= '0;
         moy_ff     <= '0;
         tile_x_ff  <= '0;
         tile_y_ff  <= '0;
         off_x_ff   <= '0;
         off_y_ff   <= '0;
         vel_x_ff   <= '0;
         vel_y_ff   <= '0;
         hold_ff    <= '0;
         active_ff  <= 1'b0;
         allowed_ff <= DIRS_RESET;
      end else begin
         step_ff    <= step_in;
         maxs_ff    <= maxs_in;
         stime_ff   <= stime_in;
         tw_ff      <= tw_in;
         mtx_ff     <= mtx_in;
         mty_ff     <= mty_in;
         mox_ff     <= mox_in;
         moy_ff     <= moy_in;
         tile_x_ff  <= tile_x_in;
         tile_y_ff  <= tile_y_in;
         off_x_ff   <= off_x_in;
         off_y_ff   <= off_y_in;
         vel_x_ff   <= vel_x_in;
         vel_y_ff   <= vel_y_in;
         hold_ff    <= hold_in;
         active_ff  <= active_in;
         allowed_ff <= allowed_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      border_ff   <= border_in;
      dout_ff     <= dout_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      pmag_x_ff   <= pmag_x_in;
      pmag_y_ff   <= pmag_y_in;
      pneg_x_ff   <= pneg_x_in;
      pneg_y_ff   <= pneg_y_in;
      q_x_ff      <= q_x_in;
      q_y_ff      <= q_y_in;
      p_ff        <= p_in;
      mp_ff       <= mp_in;
      nneg_ff     <= nneg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.vel_zero = (vel_x_ff == 8'd0) && (vel_y_ff == 8'd0);
   assign stat.div_done = div_done;
   assign rsp_tdata     = rsp_data_ff;

endmodule

// File: rtl/core/vsc_ctrl.sv
// Sequencer: steps the datapath through each request and owns both handshakes.
`timescale 1ns / 1ps

module vsc_ctrl
   import vsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  vsc_stat_type          stat,
   output vsc_cmd_type           cmd
);

   vsc_state_type state_ff, state_in;
   logic [1:0]    sel_ff, sel_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            sel_in = 2'd0;
            if (req_tvalid) begin
               case (req_tuser)
                  REQ_ACCEL: state_in = S_ACC;
                  REQ_ABS:   state_in = S_ABS_MUL;
                  REQ_TICK:  state_in = S_T_MUL;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_ACC: begin
            sel_in = sel_ff + 2'd1;
            if (sel_ff == 2'd3) begin
               state_in = S_ACC_END;
            end
         end
         S_ACC_END: state_in = S_DONE;
         S_ABS_MUL: state_in = S_ABS_RCP;
         S_ABS_RCP: state_in = S_ABS_END;
         S_ABS_END: state_in = S_DONE;
         S_T_MUL:   state_in = S_T_CLAMP;
         S_T_CLAMP: begin
            if (sel_ff[0]) begin
               sel_in   = 2'd0;
               state_in = S_T_CHECK;
            end else begin
               sel_in   = 2'd1;
               state_in = S_T_MUL;
            end
         end
         S_T_CHECK: state_in = stat.vel_zero ? S_DONE : S_T_WAIT;
         S_T_DIV:   state_in = S_T_WAIT;
         S_T_WAIT: begin
            if (stat.div_done) begin
               state_in = S_T_CARRY;
            end
         end
         S_T_CARRY: begin
            if (sel_ff[0]) begin
               sel_in   = 2'd0;
               state_in = S_T_END;
            end else begin
               sel_in   = 2'd1;
               state_in = S_T_DIV;
            end
         end
         S_T_END: state_in = S_DONE;
         S_DONE: begin
            // Hold the finished result until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd.op  = OP_IDLE;
      cmd.sel = sel_ff;
      unique case (state_ff)
         S_IDLE:    cmd.op = req_tvalid ? OP_LATCH : OP_IDLE;
         S_ACC:     cmd.op = OP_ACC_STEP;
         S_ACC_END: cmd.op = OP_ACC_END;
         S_ABS_MUL: cmd.op = OP_ABS_MUL;
         S_ABS_RCP: cmd.op = OP_ABS_RCP;
         S_ABS_END: cmd.op = OP_ABS_END;
         S_T_MUL:   cmd.op = OP_T_MUL;
         S_T_CLAMP: cmd.op = OP_T_CLAMP;
         S_T_CHECK: cmd.op = stat.vel_zero ? OP_T_STOP : OP_T_DIV;
         S_T_DIV:   cmd.op = OP_T_DIV;
         S_T_WAIT:  cmd.op = OP_IDLE;
         S_T_CARRY: cmd.op = OP_T_CARRY;
         S_T_END:   cmd.op = OP_T_END;
         S_DONE:    cmd.op = out_free ? OP_LOAD_OUT : OP_IDLE;
         default:   cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/core/viewport_scroll_controller.sv
// Tile-map viewport scroller: sequencer, datapath and result register.
//
// One request at a time; each gives one result. An accelerate request steps
// through the four directions and an end step, a pointer request through a
// multiply, a reciprocal and an end step; an unused kind goes straight to its
// result. A tick runs the bound checks, a multiply and a clamp step per axis,
// then the tile carry, a 9-step restoring divider run once per axis with its
// start and carry steps; a tick that leaves both velocities at zero ends after
// the bound checks. A new request is taken as soon as the previous result sits
// in the output register, whether or not that result has been taken yet.
`timescale 1ns / 1ps

module viewport_scroll_controller
   import vsc_pkg::*;
#(
   parameter int TILE_POS_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // direction[3:0], dx[15:4], dy[27:16], border[35:28], zero fill[39:36]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // dir_out[3:0], valid_mask[7:4], tile_x[19:8], tile_y[31:20], off_x[39:32],
   // off_y[47:40], vel_x[55:48], vel_y[63:56], scrolling[64], zero fill[71:65]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   vsc_cmd_type  cmd;
   vsc_stat_type stat;

   vsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vsc_dp #(
      .TILE_POS_BITS (TILE_POS_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

   // Only one request is in work at a time.
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in work");

   // A result never appears in the cycle right after a request is taken.
   a_no_early_result : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result raised too early after a request");

   // Velocities saturate symmetrically at 127.
   a_vel_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[55:48] != 8'h80 && rsp_tdata[63:56] != 8'h80))
      else $error("velocity outside the symmetric range");

endmodule
